@@ hdl/wbaes_pkg.sv @@
package wbaes_pkg;

    localparam int TableBytes  = 188464;
    localparam int AddrW       = 18;
    localparam int MixBase     = 10 * 16 * 256;
    localparam int MaskInBase  = MixBase + 9 * 16 * 256 * 4;
    localparam int MaskOutBase = MaskInBase + 16;
    localparam int QueueDepth  = 2;

    typedef enum logic [1:0] {
        OP_TABLE   = 2'd0,
        OP_COUNTER = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // classified request between front and back
    typedef struct packed {
        logic       is_table;
        logic       is_counter;
        logic       is_decrypt;
        logic [AddrW-1:0] address;
        logic [7:0] data_byte;
        logic       last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MASK_IN,
        ST_MIX,
        ST_FINAL,
        ST_MASK_OUT,
        ST_OUT
    } state_t;

    // source byte of state for shiftrows
    function automatic logic [3:0] shifted_src(input logic [1:0] col, input logic [1:0] row);
        logic [1:0] c;
        c = col + row;
        return {c, row};
    endfunction

endpackage

@@ hdl/wbaes_if.sv @@
interface wbaes_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [17:0] address;
    logic [7:0]  data_byte;
    logic        end_of_payload;
    modport source (output valid, operation, address, data_byte, end_of_payload, input ready);
    modport sink (input valid, operation, address, data_byte, end_of_payload, output ready);
endinterface

interface wbaes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       last_out;
    modport source (output valid, plain_byte, last_out, input ready);
    modport sink (input valid, plain_byte, last_out, output ready);
endinterface

@@ hdl/wbaes_front.sv @@
module wbaes_front
    import wbaes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wbaes_in_if.sink   in_ch,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);
    cmd_t       q_reg [QueueDepth];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push;

    // classify the incoming request
    always_comb
    begin
        c.is_table   = (op_t'(in_ch.operation) == OP_TABLE) && (in_ch.address < AddrW'(TableBytes));
        c.is_counter = (op_t'(in_ch.operation) == OP_COUNTER) && (in_ch.address < AddrW'(16));
        c.is_decrypt = (op_t'(in_ch.operation) == OP_DECRYPT);
        c.address    = in_ch.address;
        c.data_byte  = in_ch.data_byte;
        c.last       = in_ch.end_of_payload;
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready && (c.is_table || c.is_counter || c.is_decrypt);
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= c;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_pop);
        end
    end
endmodule

@@ hdl/wbaes_back.sv @@
module wbaes_back
    import wbaes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    wbaes_out_if.source out_ch
);
    logic [7:0]   mem [TableBytes];
    logic [7:0]   rd_data_reg;
    logic [AddrW-1:0] rd_addr;
    logic         rd_en;

    state_t       state_reg, state_next;
    logic [7:0]   ctr_reg [16];
    logic [7:0]   ctr_inc [16];
    logic         carry;
    logic [7:0]   ks_reg [16];
    logic [7:0]   st_reg [16];
    logic [31:0]  acc_reg [4];
    logic [3:0]   pos_reg;
    logic [3:0]   rnd_reg;
    // step counter: bit0..: byte within word, row, column; bit6 round gap
    logic [6:0]   step_reg, step_next;
    logic         pend_reg, pend_next;
    logic         fresh_reg;
    logic [7:0]   pt_reg;
    logic         last_reg;
    logic         oval_reg;

    logic [1:0]   col, row, bsel;
    logic [3:0]   slot;
    logic [7:0]   sbyte;

    assign bsel  = step_reg[1:0];
    assign row   = step_reg[3:2];
    assign col   = step_reg[5:4];
    assign slot  = {col, row};
    assign sbyte = st_reg[shifted_src(col, row)];

    // table memory, one write or one read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.is_table)
        begin
            mem[cmd.address] <= cmd.data_byte;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // read address per phase
    always_comb
    begin
        rd_addr = '0;
        rd_en   = 1'b0;
        unique case (state_reg)
            ST_MASK_IN:
            begin
                rd_en   = !step_reg[4];
                rd_addr = AddrW'(MaskInBase) + AddrW'(step_reg[3:0]);
            end
            ST_MASK_OUT:
            begin
                rd_en   = !step_reg[4];
                rd_addr = AddrW'(MaskOutBase) + AddrW'(step_reg[3:0]);
            end
            ST_MIX:
            begin
                rd_en   = !step_reg[6];
                rd_addr = AddrW'(MixBase) + {rnd_reg, 14'd0} + {4'd0, slot, 10'd0}
                        + {8'd0, sbyte, bsel};
            end
            ST_FINAL:
            begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(9 * 4096) + {6'd0, slot, sbyte};
            end
            default:
            begin
                rd_en   = 1'b0;
            end
        endcase
    end

    assign cmd_pop = cmd_valid && (state_reg == ST_IDLE) && !oval_reg
                     && !(cmd.is_decrypt && pos_reg == 4'd0 && !fresh_reg);

    // big-endian counter plus one
    always_comb
    begin
        carry = 1'b1;
        for (int j = 15; j >= 0; j--)
        begin
            ctr_inc[j] = ctr_reg[j] + {7'd0, carry};
            carry      = carry && (ctr_reg[j] == 8'hFF);
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (cmd_valid && !oval_reg && cmd.is_decrypt && pos_reg == 4'd0
                    && !fresh_reg)
                begin
                    state_next = ST_MASK_IN;
                end
            end
            ST_MASK_IN, ST_MASK_OUT:
            begin
                pend_next = !step_reg[4];
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd16)
                begin
                    state_next = (state_reg == ST_MASK_IN) ? ST_MIX : ST_OUT;
                    step_next  = '0;
                end
            end
            ST_MIX:
            begin
                // one idle step lets the round result land before the next round
                pend_next = !step_reg[6];
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd64)
                begin
                    state_next = (rnd_reg == 4'd8) ? ST_FINAL : ST_MIX;
                    step_next  = '0;
                end
            end
            ST_FINAL:
            begin
                pend_next = 1'b1;
                step_next = step_reg + 7'd4;
                if (step_reg == 7'd60)
                begin
                    state_next = ST_MASK_OUT;
                    step_next  = '0;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic [6:0] pstep_reg;
    state_t     pstate_reg;
    logic [31:0] w;
    always_comb
    begin
        w = {24'd0, rd_data_reg} << {pstep_reg[1:0], 3'd0};
    end

    // datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            pend_reg   <= 1'b0;
            pstep_reg  <= '0;
            pstate_reg <= ST_IDLE;
            rnd_reg    <= '0;
            pos_reg    <= '0;
            fresh_reg  <= 1'b0;
            oval_reg   <= 1'b0;
            pt_reg     <= '0;
            last_reg   <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                ctr_reg[i] <= '0;
                ks_reg[i]  <= '0;
                st_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            pend_reg   <= pend_next;
            pstep_reg  <= step_reg;
            pstate_reg <= state_reg;
            if (state_reg == ST_MIX && step_reg == 7'd64)
            begin
                rnd_reg <= rnd_reg + 4'd1;
            end
            if (state_reg == ST_IDLE)
            begin
                rnd_reg <= '0;
            end
            // absorb looked-up byte
            if (pend_reg)
            begin
                unique case (pstate_reg)
                    ST_MASK_IN:
                        st_reg[pstep_reg[3:0]] <= ctr_reg[pstep_reg[3:0]] ^ rd_data_reg;
                    ST_MASK_OUT:
                        ks_reg[pstep_reg[3:0]] <= ks_reg[pstep_reg[3:0]] ^ rd_data_reg;
                    ST_FINAL:
                        ks_reg[pstep_reg[5:2]] <= rd_data_reg;
                    ST_MIX:
                    begin
                        if (pstep_reg[3:0] == 4'd0)
                        begin
                            acc_reg[pstep_reg[5:4]] <= w;
                        end
                        else
                        begin
                            acc_reg[pstep_reg[5:4]] <= acc_reg[pstep_reg[5:4]] ^ w;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // commit a mixed round once all columns are done
            if (pstate_reg == ST_MIX && pstep_reg == 7'd63)
            begin
                for (int cc = 0; cc < 3; cc++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        st_reg[cc * 4 + b] <= acc_reg[cc][31 - 8 * b -: 8];
                    end
                end
                st_reg[12] <= w[31:24] ^ acc_reg[3][31:24];
                st_reg[13] <= w[23:16] ^ acc_reg[3][23:16];
                st_reg[14] <= w[15:8] ^ acc_reg[3][15:8];
                st_reg[15] <= w[7:0] ^ acc_reg[3][7:0];
            end
            // bump counter once the keystream block is built
            if (state_reg == ST_OUT)
            begin
                for (int j = 0; j < 16; j++)
                begin
                    ctr_reg[j] <= ctr_inc[j];
                end
                fresh_reg <= 1'b1;
            end
            if (cmd_pop && cmd.is_counter)
            begin
                ctr_reg[cmd.address[3:0]] <= cmd.data_byte;
            end
            if (cmd_pop && cmd.is_decrypt)
            begin
                pt_reg    <= cmd.data_byte ^ ks_reg[pos_reg];
                last_reg  <= cmd.last;
                oval_reg  <= 1'b1;
                fresh_reg <= 1'b0;
                pos_reg   <= cmd.last ? 4'd0 : pos_reg + 4'd1;
            end
            else if (out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = oval_reg;
    assign out_ch.plain_byte = pt_reg;
    assign out_ch.last_out   = last_reg;
endmodule

@@ hdl/white_box_aes128_ctr_decrypt_top.sv @@
// white-box aes-128 counter-mode decryptor
// in_ch carries requests: operation, address, data_byte, end_of_payload.
// operation 0 writes one table byte, 1 writes one counter byte, 2 decrypts
// one payload byte; out_ch returns plain_byte and last_out for decrypts only.
// a front stage classifies requests into a two-entry queue; the back stage
// owns the single-port table memory, counter and keystream registers.
// a decrypt at block position zero first builds a keystream block:
// 16 mask-in reads, 9 rounds of 64 mix-table byte reads with an idle
// step after each round to load its result, 16 t-box reads and 16
// mask-out reads, all bound by the one memory port.
// a pending result blocks the back stage until out_ch takes it; the queue
// keeps accepting requests until it holds two.
// reset clears counter, keystream, position and queue; table contents are
// undefined until written.
module white_box_aes128_ctr_decrypt_top
    import wbaes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wbaes_in_if.sink     in_ch,
    wbaes_out_if.source  out_ch
);
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    wbaes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    wbaes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );
endmodule
